>>> design/slope_height_scaler_top_assert.svh
// ----------------------------------------------------------------------------
// Slope height scaler assertion macros
// Concurrent check macros used by the scaler RTL, clocked on clk, reset rst_n.
// ----------------------------------------------------------------------------
`ifndef SLOPE_HEIGHT_SCALER_TOP_ASSERT_SVH
`define SLOPE_HEIGHT_SCALER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define SHS_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SHS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SHS_ASSERT_SAME(name, ante, cons, msg)
`define SHS_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

>>> design/shs_pkg.sv
// ----------------------------------------------------------------------------
// Slope height scaler package
// Fixed widths shared by the scaler modules.
// ----------------------------------------------------------------------------
package shs_pkg;
    localparam int IN_W   = 32;
    localparam int PROD_W = 64;
    localparam int OUT_W  = 34;
endpackage

>>> design/shs_front.sv
// ----------------------------------------------------------------------------
// Slope height scaler front end
// Converts the coordinate to scale format and forms its 64-bit square.
// ----------------------------------------------------------------------------
module shs_front #(
    parameter int SCALE_BITS      = 16,
    parameter int COORD_FRAC_BITS = 16,
    parameter int WL              = 48
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            valid_in,
    input  logic signed [shs_pkg::IN_W-1:0] dy_in,
    output logic                            valid_out,
    output logic signed [WL-1:0]            lo_out,
    output logic [shs_pkg::PROD_W-1:0]      sq_out,
    output logic [shs_pkg::PROD_W-1:0]      v_out
);
    localparam int H  = (WL + 1) / 2;
    localparam int PW = shs_pkg::PROD_W;

    logic signed [WL-1:0] scaled;
    logic signed [WL-1:0] lo_a_reg;
    logic                 va_reg;
    logic [WL-1:0]        mag;
    logic [WL-H-1:0]      mh;
    logic [H-1:0]         ml;
    logic signed [WL-1:0] lo_b_reg;
    logic [2*(WL-H)-1:0]  phh_reg;
    logic [WL-1:0]        phl_reg;
    logic [2*H-1:0]       pll_reg;
    logic                 vb_reg;
    logic [PW-1:0]        sq_sum;
    logic signed [WL-1:0] lo_c_reg;
    logic [PW-1:0]        sq_reg;
    logic [PW-1:0]        v_reg;
    logic                 vc_reg;

    assign scaled = $signed({dy_in, {SCALE_BITS{1'b0}}}) >>> COORD_FRAC_BITS;
    assign mag    = lo_a_reg[WL-1] ? WL'(0) - WL'(lo_a_reg) : WL'(lo_a_reg);
    assign mh     = mag[WL-1:H];
    assign ml     = mag[H-1:0];

    // The square of the magnitude is split into three narrow partial products.
    assign sq_sum = (PW'(phh_reg) << (2 * H)) + (PW'(phl_reg) << (H + 1)) + PW'(pll_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= valid_in;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_a_reg <= scaled;
            lo_b_reg <= lo_a_reg;
            phh_reg  <= mh * mh;
            phl_reg  <= WL'(mh) * WL'(ml);
            pll_reg  <= ml * ml;
            lo_c_reg <= lo_b_reg;
            sq_reg   <= sq_sum;
            v_reg    <= sq_sum + (PW'(1) << (2 * SCALE_BITS));
        end
    end

    assign valid_out = vc_reg;
    assign lo_out    = lo_c_reg;
    assign sq_out    = sq_reg;
    assign v_out     = v_reg;
endmodule

>>> design/shs_bisect_cell.sv
// ----------------------------------------------------------------------------
// Slope height scaler bisection cell
// One bisection step; the square of the midpoint is updated by shifts and adds.
// ----------------------------------------------------------------------------
module shs_bisect_cell #(
    parameter int WL       = 48,
    parameter int LOG_HALF = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       valid_in,
    input  logic signed [WL-1:0]       lo_in,
    input  logic [shs_pkg::PROD_W-1:0] sq_in,
    input  logic [shs_pkg::PROD_W-1:0] v_in,
    output logic                       valid_out,
    output logic signed [WL-1:0]       lo_out,
    output logic [shs_pkg::PROD_W-1:0] sq_out,
    output logic [shs_pkg::PROD_W-1:0] v_out
);
    localparam int PW = shs_pkg::PROD_W;

    logic signed [WL-1:0] mid;
    logic [PW-1:0]        lo_ext;
    logic [PW-1:0]        mid_sq;
    logic                 take;
    logic                 valid_reg;
    logic signed [WL-1:0] lo_reg;
    logic [PW-1:0]        sq_reg;
    logic [PW-1:0]        v_reg;

    assign mid    = lo_in + (WL'(1) << LOG_HALF);
    assign lo_ext = PW'(lo_in);
    // (lo + d)^2 = lo^2 + 2*lo*d + d^2, with d a power of two, modulo 2^64.
    assign mid_sq = sq_in + (lo_ext << (LOG_HALF + 1)) + (PW'(1) << (2 * LOG_HALF));
    assign take   = $signed(mid_sq) < $signed(v_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= take ? mid : lo_in;
            sq_reg <= take ? mid_sq : sq_in;
            v_reg  <= v_in;
        end
    end

    assign valid_out = valid_reg;
    assign lo_out    = lo_reg;
    assign sq_out    = sq_reg;
    assign v_out     = v_reg;
endmodule

>>> design/shs_div_cell.sv
// ----------------------------------------------------------------------------
// Slope height scaler divider cell
// One restoring division step producing one quotient bit.
// ----------------------------------------------------------------------------
module shs_div_cell #(
    parameter int DW   = 49,
    parameter int QW   = 33,
    parameter bit NBIT = 1'b0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          valid_in,
    input  logic [DW-1:0] rem_in,
    input  logic [DW-1:0] d_in,
    input  logic [QW-1:0] q_in,
    input  logic          neg_in,
    input  logic          zero_in,
    output logic          valid_out,
    output logic [DW-1:0] rem_out,
    output logic [DW-1:0] d_out,
    output logic [QW-1:0] q_out,
    output logic          neg_out,
    output logic          zero_out
);
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic          valid_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] d_reg;
    logic [QW-1:0] q_reg;
    logic          neg_reg;
    logic          zero_reg;

    assign trial = {rem_in, NBIT};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= ge ? diff[DW-1:0] : trial[DW-1:0];
            d_reg    <= d_in;
            q_reg    <= {q_in[QW-2:0], ge};
            neg_reg  <= neg_in;
            zero_reg <= zero_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign d_out     = d_reg;
    assign q_out     = q_reg;
    assign neg_out   = neg_reg;
    assign zero_out  = zero_reg;
endmodule

>>> design/slope_height_scaler_top.sv
// ----------------------------------------------------------------------------
// Slope height scaler
// Computes 1/sqrt(1 + dy^2) by bisection followed by a pipelined division.
// ----------------------------------------------------------------------------
//  beat   | valid     | stall     | payload
//  input  | in_valid  | in_stall  | dy_coord
//  output | out_valid | out_stall | scale_out, zero_divisor
//
// One beat is accepted per cycle while in_stall is low.
// The pipeline holds one cell per bisection step and one per quotient bit.
// Reset clears all valid bits; data registers are not reset.
// A skid register behind the output register absorbs one beat; in_stall
// rises only when that skid register is full, and then the whole chain holds.
module slope_height_scaler_top #(
    parameter int SCALE_BITS      = 16,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [shs_pkg::IN_W-1:0]  dy_coord,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [shs_pkg::OUT_W-1:0] scale_out,
    output logic                             zero_divisor
);
    `include "slope_height_scaler_top_assert.svh"

    localparam int WL = shs_pkg::IN_W + SCALE_BITS;
    localparam int DW = WL + 1;
    localparam int QW = 2 * SCALE_BITS + 1;
    localparam int PW = shs_pkg::PROD_W;
    localparam int OW = shs_pkg::OUT_W;

    logic                 en;
    logic                 bv [SCALE_BITS+1];
    logic signed [WL-1:0] blo [SCALE_BITS+1];
    logic [PW-1:0]        bsq [SCALE_BITS+1];
    logic [PW-1:0]        bvv [SCALE_BITS+1];

    logic                 dv [QW+1];
    logic [DW-1:0]        drem [QW+1];
    logic [DW-1:0]        dd [QW+1];
    logic [QW-1:0]        dq [QW+1];
    logic                 dneg [QW+1];
    logic                 dzero [QW+1];

    logic signed [DW-1:0] hi;
    logic                 prep_valid_reg;
    logic [DW-1:0]        prep_d_reg;
    logic                 prep_neg_reg;
    logic                 prep_zero_reg;

    logic                 p_fire;
    logic [OW-1:0]        q_ext;
    logic [OW-1:0]        p_scale;
    logic                 p_zero;
    logic                 out_free;
    logic                 out_valid_reg;
    logic [OW-1:0]        out_scale_reg;
    logic                 out_zero_reg;
    logic                 skid_valid_reg;
    logic [OW-1:0]        skid_scale_reg;
    logic                 skid_zero_reg;

    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    shs_front #(
        .SCALE_BITS      (SCALE_BITS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .WL              (WL)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (in_valid),
        .dy_in     (dy_coord),
        .valid_out (bv[0]),
        .lo_out    (blo[0]),
        .sq_out    (bsq[0]),
        .v_out     (bvv[0])
    );

    // Step k halves an interval of length 2^(SCALE_BITS-k).
    for (genvar k = 0; k < SCALE_BITS; k++)
    begin : g_bisect
        shs_bisect_cell #(
            .WL       (WL),
            .LOG_HALF (SCALE_BITS - 1 - k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (bv[k]),
            .lo_in     (blo[k]),
            .sq_in     (bsq[k]),
            .v_in      (bvv[k]),
            .valid_out (bv[k+1]),
            .lo_out    (blo[k+1]),
            .sq_out    (bsq[k+1]),
            .v_out     (bvv[k+1])
        );
    end

    assign hi = DW'(blo[SCALE_BITS]) + DW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            prep_valid_reg <= bv[SCALE_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_d_reg    <= hi[DW-1] ? DW'(0) - DW'(hi) : DW'(hi);
            prep_neg_reg  <= hi[DW-1];
            prep_zero_reg <= (hi == '0);
        end
    end

    assign dv[0]    = prep_valid_reg;
    assign drem[0]  = '0;
    assign dd[0]    = prep_d_reg;
    assign dq[0]    = '0;
    assign dneg[0]  = prep_neg_reg;
    assign dzero[0] = prep_zero_reg;

    // The dividend 2^(2*SCALE_BITS) has its only set bit in the first step.
    for (genvar j = 0; j < QW; j++)
    begin : g_div
        shs_div_cell #(
            .DW   (DW),
            .QW   (QW),
            .NBIT ((j == 0) ? 1'b1 : 1'b0)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (dv[j]),
            .rem_in    (drem[j]),
            .d_in      (dd[j]),
            .q_in      (dq[j]),
            .neg_in    (dneg[j]),
            .zero_in   (dzero[j]),
            .valid_out (dv[j+1]),
            .rem_out   (drem[j+1]),
            .d_out     (dd[j+1]),
            .q_out     (dq[j+1]),
            .neg_out   (dneg[j+1]),
            .zero_out  (dzero[j+1])
        );
    end

    assign q_ext   = OW'(dq[QW]);
    assign p_zero  = dzero[QW];
    assign p_scale = p_zero ? '0 : (dneg[QW] ? OW'(0) - q_ext : q_ext);
    assign p_fire  = en && dv[QW];
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || p_fire;
            skid_valid_reg <= 1'b0;
        end
        else if (p_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_scale_reg <= skid_valid_reg ? skid_scale_reg : p_scale;
            out_zero_reg  <= skid_valid_reg ? skid_zero_reg : p_zero;
        end
        else if (p_fire)
        begin
            skid_scale_reg <= p_scale;
            skid_zero_reg  <= p_zero;
        end
    end

    assign out_valid    = out_valid_reg;
    assign scale_out    = $signed(out_scale_reg);
    assign zero_divisor = out_zero_reg;

    `SHS_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full without output")
    `SHS_ASSERT_NEXT(a_skid_drains, skid_valid_reg && !out_stall, !skid_valid_reg, "skid not drained")
    `SHS_ASSERT_SAME(a_zero_result, out_valid_reg && out_zero_reg, out_scale_reg == '0, "zero divisor with nonzero scale")
endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Slope height scaler testbench
// Drives coordinate differences with random gaps and output stalls, predicts
// each scale factor in a scoreboard, and compares every result beat in order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCALE_BITS      = 16;
    localparam int COORD_FRAC_BITS = 16;
    localparam int NUM_RANDOM      = 1200;
    localparam int LATENCY         = 3 * SCALE_BITS + 6;
    localparam int CYCLE_LIMIT     = 400000;

    typedef struct {
        logic signed [shs_pkg::OUT_W-1:0] scale;
        logic                             zero_div;
    } scale_result_t;

    class scale_scoreboard;
        scale_result_t expected_scales[$];
        int            mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Bisection for sqrt(lo^2 + 1), then one divided by the upper bound.
        function scale_result_t predict_scale(logic signed [shs_pkg::IN_W-1:0] dy);
            scale_result_t r;
            longint lo, hi, target, mid, mag, quot;
            lo = (longint'(dy) * (longint'(1) << SCALE_BITS)) >>> COORD_FRAC_BITS;
            hi = lo + (longint'(1) << SCALE_BITS);
            target = lo * lo + (longint'(1) << (2 * SCALE_BITS));
            while (hi > lo + 1)
            begin
                mid = (hi + lo) >>> 1;
                if (mid * mid < target)
                    lo = mid;
                else
                    hi = mid;
            end
            if (hi == 0)
            begin
                r.scale = '0;
                r.zero_div = 1'b1;
            end
            else
            begin
                mag = (hi < 0) ? -hi : hi;
                quot = (longint'(1) << (2 * SCALE_BITS)) / mag;
                if (hi < 0)
                    quot = -quot;
                r.scale = quot[shs_pkg::OUT_W-1:0];
                r.zero_div = 1'b0;
            end
            return r;
        endfunction

        function void note_input(logic signed [shs_pkg::IN_W-1:0] dy);
            expected_scales.push_back(predict_scale(dy));
        endfunction

        function void check_result(logic signed [shs_pkg::OUT_W-1:0] scale, logic zero_div);
            scale_result_t exp_r;
            if (expected_scales.size() == 0)
            begin
                $display("%0t: unexpected result beat scale=%0d zero_divisor=%0b",
                         $time, scale, zero_div);
                mismatches++;
                return;
            end
            exp_r = expected_scales.pop_front();
            if (scale !== exp_r.scale)
            begin
                $display("%0t: scale_out expected %0d actual %0d", $time, exp_r.scale, scale);
                mismatches++;
            end
            if (zero_div !== exp_r.zero_div)
            begin
                $display("%0t: zero_divisor expected %0b actual %0b",
                         $time, exp_r.zero_div, zero_div);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_scales.size();
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic signed [shs_pkg::IN_W-1:0]  dy_coord;
    logic                             out_valid;
    logic                             out_stall;
    logic signed [shs_pkg::OUT_W-1:0] scale_out;
    logic                             zero_divisor;

    scale_scoreboard sb;
    bit              long_hold_req;
    int              cycle_count;

    slope_height_scaler_top #(
        .SCALE_BITS      (SCALE_BITS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .dy_coord     (dy_coord),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .scale_out    (scale_out),
        .zero_divisor (zero_divisor)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b1;
        dy_coord = '0;
        long_hold_req = 1'b0;
        cycle_count = 0;
        sb = new();
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Presents one beat and returns at the edge where it is taken.
    task automatic send_beat(logic signed [shs_pkg::IN_W-1:0] value, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        dy_coord <= value;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(value);
    endtask

    function automatic logic signed [shs_pkg::IN_W-1:0] random_dy();
        int sel;
        logic [shs_pkg::IN_W-1:0] mag;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2: return $urandom();
            3, 4:    return $signed(32'($urandom_range(0, 8 << COORD_FRAC_BITS)))
                            - (4 << COORD_FRAC_BITS);
            5, 6:    return -$signed(32'($urandom_range(0, 1 << (COORD_FRAC_BITS + 1))));
            7:       return $signed(32'($urandom_range(0, 64))) - 32;
            default:
            begin
                mag = $urandom() >> $urandom_range(0, 31);
                return ($urandom_range(0, 1) != 0) ? -$signed(mag) : $signed(mag);
            end
        endcase
    endfunction

    function automatic int draw_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    endfunction

    // Receiver: random stalls per beat, plus one long hold on request.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                n = 400;
                long_hold_req = 1'b0;
            end
            else
                n = draw_gap();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_result(scale_out, zero_divisor);
        end
    end

    initial
    begin
        logic signed [shs_pkg::IN_W-1:0] directed[$];
        directed = '{32'sd0, 32'sd1, -32'sd1, 32'sh7fffffff, 32'sh80000000,
                     32'sd65536, -32'sd65536, -32'sd32768, -32'sd32769, -32'sd65537,
                     32'sd32768, -32'sd131072, 32'sd131072, -32'sd2, -32'sd98304,
                     32'sh55555555, 32'shaaaaaaaa, -32'sd16384, -32'sd49152,
                     32'sh00ffffff, 32'shff000000, -32'sd65535};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_beat(directed[i], (i < 8) ? 0 : draw_gap());
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i == 300)
                long_hold_req = 1'b1;
            if (i == 700)
            begin
                // Let the pipeline drain completely before continuing.
                in_valid <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            send_beat(random_dy(), (i >= 300 && i < 420) ? 0 : draw_gap());
        end
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+design
design/shs_pkg.sv
design/shs_front.sv
design/shs_bisect_cell.sv
design/shs_div_cell.sv
design/slope_height_scaler_top.sv
test/testbench.sv
